// ----- src/fsq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_pkg
// Shared constants, register codes and types for the flat-shaded quad block.
// ----------------------------------------------------------------------------
package fsq_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS      = 14;
  localparam int LANE_BITS      = 16;
  localparam int COLOR_BITS     = 16;
  localparam int NUM_COLORS     = 4;
  localparam int NUM_ROT        = 12;   // four corners times three axes
  localparam int NUM_VERTS      = 6;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int ROW_BITS       = 3 * LANE_BITS;
  localparam int RGBA_BITS      = NUM_COLORS * COLOR_BITS;

  // normal arithmetic
  localparam int MAG_BITS = 30;
  localparam int SUM_BITS = 2 * MAG_BITS + 2;
  localparam int LEN_BITS = MAG_BITS + 1;
  localparam int QUO_BITS = FRAC_BITS + 1;
  localparam int NRM_BITS = 16;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW0    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW1    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW2    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIGHT   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_AMBIENT = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIFFUSE = 3'd5;

  localparam logic [ROW_BITS-1:0]  RST_ROW0    = 48'd16384;
  localparam logic [ROW_BITS-1:0]  RST_ROW1    = 48'd1073741824;
  localparam logic [ROW_BITS-1:0]  RST_ROW2    = 48'd70368744177664;
  localparam logic [ROW_BITS-1:0]  RST_LIGHT   = 48'd211106232532992;
  localparam logic [RGBA_BITS-1:0] RST_AMBIENT = 64'd4611700093035220173;
  localparam logic [RGBA_BITS-1:0] RST_DIFFUSE = 64'd4611686019286384640;

  typedef struct packed {
    logic [ROW_BITS-1:0]  row0;
    logic [ROW_BITS-1:0]  row1;
    logic [ROW_BITS-1:0]  row2;
    logic [ROW_BITS-1:0]  light;
    logic [RGBA_BITS-1:0] ambient;
    logic [RGBA_BITS-1:0] diffuse;
  } regs_t;

endpackage

// ----- src/fsq_rotate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_rotate
// Two-stage rotation of the four corners by the 3x3 matrix, with rounding
// and saturation to the coordinate width.
// ----------------------------------------------------------------------------
module fsq_rotate
  import fsq_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [NUM_ROT*COORD_BITS-1:0] corners,
  input  regs_t                        cfg,
  output logic                         out_valid,
  output logic [NUM_ROT*COORD_BITS-1:0] rot
);

  localparam int PW = COORD_BITS + LANE_BITS;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [SW-1:0] ROUND  = SW'(1) << (FRAC_BITS - 1);

  logic [ROW_BITS-1:0]    row [3];
  logic signed [PW-1:0]   prod_c [NUM_ROT][3];
  logic signed [PW-1:0]   prod   [NUM_ROT][3];
  logic [COORD_BITS-1:0]  rot_c  [NUM_ROT];
  logic                   prod_valid;

  assign row[0] = cfg.row0;
  assign row[1] = cfg.row1;
  assign row[2] = cfg.row2;

  always_comb begin
    logic signed [PW-1:0] coef;
    logic signed [PW-1:0] pt;
    for (int v = 0; v < 4; v++) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          coef = $signed(row[r][LANE_BITS*j +: LANE_BITS]);
          pt   = $signed(corners[(v*3 + j)*COORD_BITS +: COORD_BITS]);
          prod_c[v*3 + r][j] = coef * pt;
        end
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] sh;
    for (int i = 0; i < NUM_ROT; i++) begin
      acc = ROUND;
      acc = acc + prod[i][0] + prod[i][1] + prod[i][2];
      sh  = acc >>> FRAC_BITS;
      if (sh > SAT_HI) begin
        rot_c[i] = SAT_HI[COORD_BITS-1:0];
      end else if (sh < SAT_LO) begin
        rot_c[i] = SAT_LO[COORD_BITS-1:0];
      end else begin
        rot_c[i] = sh[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (en) begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_c;
      for (int i = 0; i < NUM_ROT; i++) begin
        rot[i*COORD_BITS +: COORD_BITS] <= rot_c[i];
      end
    end
  end

endmodule

// ----- src/fsq_normal.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_normal
// Face normal pipeline: edges, cross product, range reduction, squared
// length, bit-per-stage square root and bit-per-stage division.
// ----------------------------------------------------------------------------
module fsq_normal
  import fsq_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [NUM_ROT*COORD_BITS-1:0] in_rot,
  output logic                          out_valid,
  output logic [NUM_ROT*COORD_BITS-1:0] out_rot,
  output logic [3*NRM_BITS-1:0]         nrm
);

  localparam int RW    = NUM_ROT * COORD_BITS;
  localparam int ES    = (COORD_BITS > 16) ? COORD_BITS - 16 : 0;
  localparam int EW    = COORD_BITS + 1 - ES;
  localparam int PP    = 2 * EW;
  localparam int MAXS  = (PP > MAG_BITS) ? PP - MAG_BITS : 0;
  localparam int SH_W  = $clog2(MAXS + 2);
  localparam int REM_W = MAG_BITS + FRAC_BITS + 2;
  localparam int SQP_W = RW + 3*MAG_BITS + 3;
  localparam int DVP_W = RW + 3 + 1;

  // edge stage
  logic                 e_valid;
  logic [RW-1:0]        e_rot;
  logic signed [EW-1:0] e1 [3], e2 [3], e1_c [3], e2_c [3];
  // product stage
  logic                 p_valid;
  logic [RW-1:0]        p_rot;
  logic signed [PP-1:0] pa [3], pb [3], pa_c [3], pb_c [3];
  // magnitude stage
  logic                 m_valid;
  logic [RW-1:0]        m_rot;
  logic [PP-1:0]        mag [3], mag_c [3];
  logic [2:0]           m_sgn, m_sgn_c;
  // reduced stage
  logic                 n_valid;
  logic [RW-1:0]        n_rot;
  logic [MAG_BITS-1:0]  m30 [3], m30_c [3];
  logic [2:0]           n_sgn;
  // square stage
  logic                 q_valid;
  logic [RW-1:0]        q_rot;
  logic [2*MAG_BITS-1:0] sqr [3];
  logic [MAG_BITS-1:0]  q_m30 [3];
  logic [2:0]           q_sgn;

  // square root pipeline
  logic                 sq_v   [0:LEN_BITS];
  logic [SUM_BITS-1:0]  sq_x   [0:LEN_BITS];
  logic [SUM_BITS-1:0]  sq_r   [0:LEN_BITS];
  logic [SQP_W-1:0]     sq_pay [0:LEN_BITS];

  // divider pipeline
  logic                 dv_v   [0:QUO_BITS];
  logic [REM_W-1:0]     dv_rem [0:QUO_BITS][3];
  logic [QUO_BITS-1:0]  dv_q   [0:QUO_BITS][3];
  logic [LEN_BITS-1:0]  dv_len [0:QUO_BITS];
  logic [DVP_W-1:0]     dv_pay [0:QUO_BITS];

  logic [NRM_BITS-1:0]  nrm_c [3];

  // edges B-A and C-B
  always_comb begin
    logic signed [COORD_BITS:0] pa0, pb0, pc0;
    logic signed [COORD_BITS:0] d1, d2;
    for (int j = 0; j < 3; j++) begin
      pa0 = $signed(in_rot[(0*3 + j)*COORD_BITS +: COORD_BITS]);
      pb0 = $signed(in_rot[(1*3 + j)*COORD_BITS +: COORD_BITS]);
      pc0 = $signed(in_rot[(2*3 + j)*COORD_BITS +: COORD_BITS]);
      d1 = pb0 - pa0;
      d2 = pc0 - pb0;
      e1_c[j] = EW'(d1 >>> ES);
      e2_c[j] = EW'(d2 >>> ES);
    end
  end

  always_comb begin
    logic signed [PP-1:0] x1 [3];
    logic signed [PP-1:0] x2 [3];
    for (int j = 0; j < 3; j++) begin
      x1[j] = e1[j];
      x2[j] = e2[j];
    end
    pa_c[0] = x1[1] * x2[2];
    pb_c[0] = x1[2] * x2[1];
    pa_c[1] = x1[2] * x2[0];
    pb_c[1] = x1[0] * x2[2];
    pa_c[2] = x1[0] * x2[1];
    pb_c[2] = x1[1] * x2[0];
  end

  always_comb begin
    logic signed [PP:0] cr, a, b;
    for (int j = 0; j < 3; j++) begin
      a  = pa[j];
      b  = pb[j];
      cr = a - b;
      m_sgn_c[j] = cr[PP];
      mag_c[j]   = cr[PP] ? PP'(-cr) : PP'(cr);
    end
  end

  // common shift so that every magnitude is below 2^30
  always_comb begin
    logic [PP-1:0]   orm;
    logic [SH_W-1:0] s;
    logic [63:0]     t;
    orm = mag[0] | mag[1] | mag[2];
    s   = '0;
    for (int k = MAXS; k >= 0; k--) begin
      if ((64'(orm) >> k) < (64'd1 << MAG_BITS)) s = SH_W'(k);
    end
    for (int j = 0; j < 3; j++) begin
      t = 64'(mag[j]) >> s;
      m30_c[j] = t[MAG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      p_valid <= 1'b0;
      m_valid <= 1'b0;
      n_valid <= 1'b0;
      q_valid <= 1'b0;
      sq_v[0] <= 1'b0;
    end else if (en) begin
      e_valid <= in_valid;
      p_valid <= e_valid;
      m_valid <= p_valid;
      n_valid <= m_valid;
      q_valid <= n_valid;
      sq_v[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [2*MAG_BITS-1:0] a;
    if (en) begin
      e_rot <= in_rot;
      e1    <= e1_c;
      e2    <= e2_c;
      p_rot <= e_rot;
      pa    <= pa_c;
      pb    <= pb_c;
      m_rot <= p_rot;
      mag   <= mag_c;
      m_sgn <= m_sgn_c;
      n_rot <= m_rot;
      m30   <= m30_c;
      n_sgn <= m_sgn;
      q_rot <= n_rot;
      q_m30 <= m30;
      q_sgn <= n_sgn;
      for (int j = 0; j < 3; j++) begin
        a = (2*MAG_BITS)'(m30[j]);
        sqr[j] <= a * a;
      end
      sq_x[0]   <= SUM_BITS'(sqr[0]) + SUM_BITS'(sqr[1]) + SUM_BITS'(sqr[2]);
      sq_r[0]   <= '0;
      sq_pay[0] <= {q_sgn, q_m30[2], q_m30[1], q_m30[0], q_rot};
    end
  end

  // one result bit per stage
  for (genvar i = 0; i < LEN_BITS; i++) begin : g_sqrt
    localparam logic [SUM_BITS-1:0] BIT = SUM_BITS'(1) << (2*(LEN_BITS - 1 - i));
    logic [SUM_BITS-1:0] trial;
    assign trial = sq_r[i] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[i+1] <= 1'b0;
      end else if (en) begin
        sq_v[i+1] <= sq_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_pay[i+1] <= sq_pay[i];
        if (sq_x[i] >= trial) begin
          sq_x[i+1] <= sq_x[i] - trial;
          sq_r[i+1] <= (sq_r[i] >> 1) + BIT;
        end else begin
          sq_x[i+1] <= sq_x[i];
          sq_r[i+1] <= sq_r[i] >> 1;
        end
      end
    end
  end

  // divider entry: rounded numerator mag*2^14 + len/2
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[LEN_BITS];
    end
  end

  always_ff @(posedge clk) begin
    logic [LEN_BITS-1:0] len;
    logic [MAG_BITS-1:0] mg;
    if (en) begin
      len = sq_r[LEN_BITS][LEN_BITS-1:0];
      for (int j = 0; j < 3; j++) begin
        mg = sq_pay[LEN_BITS][RW + j*MAG_BITS +: MAG_BITS];
        dv_rem[0][j] <= (REM_W'(mg) << FRAC_BITS) + REM_W'(len >> 1);
        dv_q[0][j]   <= '0;
      end
      dv_len[0] <= len;
      dv_pay[0] <= {(len == '0), sq_pay[LEN_BITS][RW + 3*MAG_BITS +: 3],
                    sq_pay[LEN_BITS][RW-1:0]};
    end
  end

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
    localparam int K = QUO_BITS - 1 - i;
    logic [REM_W-1:0] dvs;
    assign dvs = REM_W'(dv_len[i]) << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[i+1] <= 1'b0;
      end else if (en) begin
        dv_v[i+1] <= dv_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_len[i+1] <= dv_len[i];
        dv_pay[i+1] <= dv_pay[i];
        for (int j = 0; j < 3; j++) begin
          if (dv_rem[i][j] >= dvs) begin
            dv_rem[i+1][j] <= dv_rem[i][j] - dvs;
            dv_q[i+1][j]   <= {dv_q[i][j][QUO_BITS-2:0], 1'b1};
          end else begin
            dv_rem[i+1][j] <= dv_rem[i][j];
            dv_q[i+1][j]   <= {dv_q[i][j][QUO_BITS-2:0], 1'b0};
          end
        end
      end
    end
  end

  // sign restore; a zero-length cross product gives a zero normal
  always_comb begin
    logic [NRM_BITS-1:0] mq;
    for (int j = 0; j < 3; j++) begin
      mq = NRM_BITS'(dv_q[QUO_BITS][j]);
      if (dv_pay[QUO_BITS][RW + 3]) begin
        nrm_c[j] = '0;
      end else if (dv_pay[QUO_BITS][RW + j]) begin
        nrm_c[j] = -mq;
      end else begin
        nrm_c[j] = mq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_v[QUO_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rot <= dv_pay[QUO_BITS][RW-1:0];
      nrm     <= {nrm_c[2], nrm_c[1], nrm_c[0]};
    end
  end

endmodule

// ----- src/fsq_shade.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_shade
// Lambert term: light dot normal, diffuse scaling, ambient add and
// saturation of the four colour channels.
// ----------------------------------------------------------------------------
module fsq_shade
  import fsq_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [NUM_ROT*COORD_BITS-1:0] in_rot,
  input  logic [3*NRM_BITS-1:0]         nrm,
  input  regs_t                         cfg,
  output logic                          out_valid,
  output logic [NUM_ROT*COORD_BITS-1:0] out_rot,
  output logic [RGBA_BITS-1:0]          color
);

  localparam int RW   = NUM_ROT * COORD_BITS;
  localparam int DPW  = LANE_BITS + NRM_BITS;
  localparam int ACW  = DPW + 2;
  localparam int DMW  = ACW - FRAC_BITS - 1;   // positive dd fits here
  localparam int TPW  = DMW + COLOR_BITS;
  localparam int CW   = TPW - FRAC_BITS + 2;
  localparam logic [COLOR_BITS-1:0] COLOR_MAX = '1;

  logic                  a_valid, b_valid, c_valid;
  logic [RW-1:0]         a_rot, b_rot, c_rot;
  logic signed [DPW-1:0] dp [3];
  logic [DMW-1:0]        dmag;
  logic                  b_pos, c_pos;
  logic [TPW-1:0]        tp [NUM_COLORS];
  logic [COLOR_BITS-1:0] col_c [NUM_COLORS];
  logic [DMW-1:0]        dmag_c;
  logic                  pos_c;

  always_comb begin
    logic signed [ACW-1:0] acc;
    logic signed [ACW-1:0] dd;
    acc = ACW'(1) << (FRAC_BITS - 1);
    acc = acc + dp[0] + dp[1] + dp[2];
    dd  = acc >>> FRAC_BITS;
    pos_c  = !dd[ACW-1] && (dd != '0);
    dmag_c = dd[DMW-1:0];
  end

  always_comb begin
    logic [CW-1:0] term;
    logic [CW-1:0] sum;
    for (int k = 0; k < NUM_COLORS; k++) begin
      if (c_pos) begin
        term = CW'((tp[k] + (TPW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
      end else if (k == NUM_COLORS - 1) begin
        term = CW'(1) << FRAC_BITS;
      end else begin
        term = '0;
      end
      sum = CW'(cfg.ambient[COLOR_BITS*k +: COLOR_BITS]) + term;
      col_c[k] = (sum > CW'(COLOR_MAX)) ? COLOR_MAX : sum[COLOR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [DPW-1:0] l;
    logic signed [DPW-1:0] n;
    if (en) begin
      a_rot <= in_rot;
      for (int j = 0; j < 3; j++) begin
        l = $signed(cfg.light[LANE_BITS*j +: LANE_BITS]);
        n = $signed(nrm[NRM_BITS*j +: NRM_BITS]);
        dp[j] <= l * n;
      end
      b_rot <= a_rot;
      dmag  <= dmag_c;
      b_pos <= pos_c;
      c_rot <= b_rot;
      c_pos <= b_pos;
      for (int k = 0; k < NUM_COLORS; k++) begin
        tp[k] <= TPW'(dmag) * TPW'(cfg.diffuse[COLOR_BITS*k +: COLOR_BITS]);
      end
      out_rot <= c_rot;
      for (int k = 0; k < NUM_COLORS; k++) begin
        color[COLOR_BITS*k +: COLOR_BITS] <= col_c[k];
      end
    end
  end

endmodule

// ----- src/fsq_serial.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_serial
// Output stage: holds one shaded face and sends its six vertices A,B,C,A,C,D.
// ----------------------------------------------------------------------------
module fsq_serial
  import fsq_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int OUT_W = ((3*COORD_BITS + RGBA_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [NUM_ROT*COORD_BITS-1:0] in_rot,
  input  logic [RGBA_BITS-1:0]          in_color,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OUT_W-1:0]              m_axis_tdata,
  output logic                          m_axis_tlast
);

  localparam int VW = 3 * COORD_BITS;
  localparam int CNT_W = $clog2(NUM_VERTS);
  localparam logic [CNT_W-1:0] LAST_VERT = CNT_W'(NUM_VERTS - 1);

  logic                          full;
  logic [CNT_W-1:0]              cnt;
  logic [NUM_ROT*COORD_BITS-1:0] rot_h;
  logic [RGBA_BITS-1:0]          color_h;
  logic [1:0]                    corner;
  logic                          load;

  always_comb begin
    unique case (cnt)
      3'd0:    corner = 2'd0;
      3'd1:    corner = 2'd1;
      3'd2:    corner = 2'd2;
      3'd3:    corner = 2'd0;
      3'd4:    corner = 2'd2;
      3'd5:    corner = 2'd3;
      default: corner = 2'd0;
    endcase
  end

  assign m_axis_tvalid = full;
  assign m_axis_tlast  = (cnt == LAST_VERT);
  assign m_axis_tdata  = OUT_W'({color_h, rot_h[corner*VW +: VW]});
  assign in_ready      = !full || (m_axis_tready && m_axis_tlast);
  assign load          = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      full <= 1'b1;
      cnt  <= '0;
    end else if (full && m_axis_tready) begin
      if (m_axis_tlast) begin
        full <= 1'b0;
        cnt  <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rot_h   <= in_rot;
      color_h <= in_color;
    end
  end

endmodule

// ----- src/flat_shaded_quad_lighting.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flat_shaded_quad_lighting
// Rotates a quad, finds its face normal and emits six flat-lit vertices.
// ----------------------------------------------------------------------------
// One quad face enters on the s_axis channel as twelve corner coordinates.
// Each face leaves on m_axis as six vertex transfers A,B,C,A,C,D, all with
// the same colour; tlast marks the sixth. Registers are written over the
// cfg channel (index, data), which is always ready; write only while idle.
// Throughput is set by the output stage, which sends one vertex per cycle
// while m_axis_tready is high; the 60-stage pipeline in front of it takes a
// face in any cycle in which the output stage is free or sends its last
// vertex. The square root takes one bit per stage (31 stages) and the
// normal division one quotient bit per stage (15 stages).
// Reset clears all valid bits and loads the default registers: identity
// matrix, light (0,0,-1) and the default ambient and diffuse colours.
// When the receiver stalls, the whole pipeline holds and s_axis_tready
// drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module flat_shaded_quad_lighting
  import fsq_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_W  = ((NUM_ROT*COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3*COORD_BITS + RGBA_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // corner_a_x, _a_y, _a_z, _b_x .. _d_z
  input  logic [IN_W-1:0]          s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // vertex_x, vertex_y, vertex_z, color_r, color_g, color_b, color_a
  output logic [OUT_W-1:0]         m_axis_tdata,
  output logic                     m_axis_tlast,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int RW = NUM_ROT * COORD_BITS;

  regs_t                cfg;
  logic                 pipe_en;
  logic                 rot_valid, nrm_valid, sh_valid;
  logic [RW-1:0]        rot_flat, nrm_rot, sh_rot;
  logic [3*NRM_BITS-1:0] nrm_flat;
  logic [RGBA_BITS-1:0] sh_color;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = pipe_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row0    <= RST_ROW0;
      cfg.row1    <= RST_ROW1;
      cfg.row2    <= RST_ROW2;
      cfg.light   <= RST_LIGHT;
      cfg.ambient <= RST_AMBIENT;
      cfg.diffuse <= RST_DIFFUSE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW0:    cfg.row0    <= cfg_data[ROW_BITS-1:0];
        REG_ROW1:    cfg.row1    <= cfg_data[ROW_BITS-1:0];
        REG_ROW2:    cfg.row2    <= cfg_data[ROW_BITS-1:0];
        REG_LIGHT:   cfg.light   <= cfg_data[ROW_BITS-1:0];
        REG_AMBIENT: cfg.ambient <= cfg_data[RGBA_BITS-1:0];
        REG_DIFFUSE: cfg.diffuse <= cfg_data[RGBA_BITS-1:0];
        default: ;
      endcase
    end
  end

  fsq_rotate #(.COORD_BITS(COORD_BITS)) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (s_axis_tvalid),
    .corners   (s_axis_tdata[RW-1:0]),
    .cfg       (cfg),
    .out_valid (rot_valid),
    .rot       (rot_flat)
  );

  fsq_normal #(.COORD_BITS(COORD_BITS)) u_normal (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (rot_valid),
    .in_rot    (rot_flat),
    .out_valid (nrm_valid),
    .out_rot   (nrm_rot),
    .nrm       (nrm_flat)
  );

  fsq_shade #(.COORD_BITS(COORD_BITS)) u_shade (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (nrm_valid),
    .in_rot    (nrm_rot),
    .nrm       (nrm_flat),
    .cfg       (cfg),
    .out_valid (sh_valid),
    .out_rot   (sh_rot),
    .color     (sh_color)
  );

  fsq_serial #(.COORD_BITS(COORD_BITS)) u_serial (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (sh_valid),
    .in_ready      (pipe_en),
    .in_rot        (sh_rot),
    .in_color      (sh_color),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- src/fsq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_checker
// Port-level checks: reset, back-pressure, vertex framing and face colour.
// ----------------------------------------------------------------------------
module fsq_checker
  import fsq_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_W  = ((NUM_ROT*COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3*COORD_BITS + RGBA_BITS + 7) / 8) * 8
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic [IN_W-1:0]          s_axis_tdata,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [OUT_W-1:0]         m_axis_tdata,
  input logic                     m_axis_tlast,
  input logic                     cfg_valid,
  input logic                     cfg_ready,
  input logic [CFG_IDX_BITS-1:0]  cfg_index,
  input logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int CNT_W = $clog2(NUM_VERTS);
  localparam logic [CNT_W-1:0] LAST_VERT = CNT_W'(NUM_VERTS - 1);

  logic                 m_xfer;
  logic [CNT_W-1:0]     vcnt;
  logic [RGBA_BITS-1:0] face_color;
  logic [RGBA_BITS-1:0] out_color;

  assign m_xfer    = m_axis_tvalid && m_axis_tready;
  assign out_color = m_axis_tdata[3*COORD_BITS +: RGBA_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vcnt <= '0;
    end else if (m_xfer) begin
      vcnt <= m_axis_tlast ? '0 : vcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_xfer) begin
      face_color <= out_color;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_last_on_sixth: assert property (@(posedge clk) disable iff (rst)
    m_xfer |-> (m_axis_tlast == (vcnt == LAST_VERT)))
    else $error("tlast not on sixth vertex");

  a_face_color: assert property (@(posedge clk) disable iff (rst)
    (m_xfer && (vcnt != '0)) |-> (out_color == face_color))
    else $error("colour changed within a face");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output changed");

endmodule

bind flat_shaded_quad_lighting fsq_checker #(.COORD_BITS(COORD_BITS)) u_fsq_checker (.*);

// ----- tb/sv/tb_flat_shaded_quad_lighting.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flat_shaded_quad_lighting
// Self-checking bench for the flat-shaded quad lighting block.
// ----------------------------------------------------------------------------
// Faces are pushed on s_axis; a behavioural model rotates the corners,
// forms the face normal and colour, and queues six expected vertices per
// face. A monitor compares every m_axis transfer field by field. Register
// settings (identity, extremes, random) are changed only while idle.
// ----------------------------------------------------------------------------
module tb_flat_shaded_quad_lighting;
  import fsq_pkg::*;

  localparam int CB    = COORD_BITS_DEF;
  localparam int IN_W  = ((NUM_ROT*CB + 7) / 8) * 8;
  localparam int OUT_W = ((3*CB + RGBA_BITS + 7) / 8) * 8;
  localparam int LATENCY = 80;

  typedef struct packed {
    logic [CB-1:0] x, y, z;
    logic [15:0]   r, g, b, a;
    logic          last;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  flat_shaded_quad_lighting #(.COORD_BITS(CB)) i_dut (.*);

  regs_t   shade_regs;
  vertex_t vertex_queue[$];
  int      errors = 0;
  int      faces_sent = 0;
  int      verts_seen = 0;
  int      degenerate_faces = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_off = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #50ms;
    $display("tb_flat_shaded_quad_lighting: errors");
    $finish;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= res + bit_v) begin
        x -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic longint sat_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (CB-1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint lane(logic [63:0] reg_v, int k);
    logic signed [15:0] l;
    l = reg_v[16*k +: 16];
    return longint'(l);
  endfunction

  // model one face, queue its six vertices
  task automatic shade_face(input logic [IN_W-1:0] face);
    longint rot[4][3], e1[3], e2[3], cr[3], nrm[3], acc, dd;
    longint unsigned mag[3], maxm, sum2, len, c, q;
    logic [15:0] color[4];
    logic signed [CB-1:0] p;
    logic [ROW_BITS-1:0] rows[3];
    int s, order[6];
    vertex_t v;
    rows[0] = shade_regs.row0; rows[1] = shade_regs.row1; rows[2] = shade_regs.row2;
    order = '{0, 1, 2, 0, 2, 3};
    for (int n = 0; n < 4; n++)
      for (int r = 0; r < 3; r++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          p = face[(n*3+j)*CB +: CB];
          acc += lane(64'(rows[r]), j) * longint'(p);
        end
        rot[n][r] = sat_coord((acc + (1 << (FRAC_BITS-1))) >>> FRAC_BITS);
      end
    for (int j = 0; j < 3; j++) begin
      e1[j] = rot[1][j] - rot[0][j];
      e2[j] = rot[2][j] - rot[1][j];
    end
    cr[0] = e1[1]*e2[2] - e1[2]*e2[1];
    cr[1] = e1[2]*e2[0] - e1[0]*e2[2];
    cr[2] = e1[0]*e2[1] - e1[1]*e2[0];
    maxm = 0;
    for (int j = 0; j < 3; j++) begin
      mag[j] = cr[j] < 0 ? -cr[j] : cr[j];
      if (mag[j] > maxm) maxm = mag[j];
    end
    s = 0;
    while ((maxm >> s) >= (64'd1 << MAG_BITS)) s++;
    sum2 = 0;
    for (int j = 0; j < 3; j++) begin
      mag[j] >>= s;
      sum2 += mag[j] * mag[j];
    end
    len = floor_sqrt(sum2);
    if (len == 0) degenerate_faces++;
    for (int j = 0; j < 3; j++) begin
      if (len == 0) begin
        nrm[j] = 0;
      end else begin
        q = ((mag[j] << FRAC_BITS) + (len >> 1)) / len;
        nrm[j] = cr[j] < 0 ? -longint'(q) : longint'(q);
      end
    end
    acc = 0;
    for (int j = 0; j < 3; j++) acc += lane(64'(shade_regs.light), j) * nrm[j];
    dd = (acc + (1 << (FRAC_BITS-1))) >>> FRAC_BITS;
    for (int k = 0; k < 4; k++) begin
      c = shade_regs.ambient[16*k +: 16];
      if (dd > 0)
        c += (unsigned'(dd) * shade_regs.diffuse[16*k +: 16]
              + (64'd1 << (FRAC_BITS-1))) >> FRAC_BITS;
      else if (k == 3)
        c += 64'd1 << FRAC_BITS;
      color[k] = c > 64'hFFFF ? 16'hFFFF : c[15:0];
    end
    for (int n = 0; n < NUM_VERTS; n++) begin
      v.x = rot[order[n]][0][CB-1:0];
      v.y = rot[order[n]][1][CB-1:0];
      v.z = rot[order[n]][2][CB-1:0];
      {v.a, v.b, v.g, v.r} = {color[3], color[2], color[1], color[0]};
      v.last = (n == NUM_VERTS-1);
      vertex_queue.push_back(v);
    end
  endtask

  // receiver: random stalls plus a counted long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // vertex monitor
  always @(posedge clk) begin
    vertex_t got, exp_v;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.x = m_axis_tdata[0 +: CB];
      got.y = m_axis_tdata[CB +: CB];
      got.z = m_axis_tdata[2*CB +: CB];
      {got.a, got.b, got.g, got.r} = m_axis_tdata[3*CB +: RGBA_BITS];
      got.last = m_axis_tlast;
      verts_seen++;
      if (vertex_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex %h", $realtime, got);
      end else begin
        exp_v = vertex_queue.pop_front();
        if (got.x !== exp_v.x) begin errors++;
          $display("%0t: vertex_x exp %h got %h", $realtime, exp_v.x, got.x); end
        if (got.y !== exp_v.y) begin errors++;
          $display("%0t: vertex_y exp %h got %h", $realtime, exp_v.y, got.y); end
        if (got.z !== exp_v.z) begin errors++;
          $display("%0t: vertex_z exp %h got %h", $realtime, exp_v.z, got.z); end
        if (got.r !== exp_v.r) begin errors++;
          $display("%0t: color_r exp %h got %h", $realtime, exp_v.r, got.r); end
        if (got.g !== exp_v.g) begin errors++;
          $display("%0t: color_g exp %h got %h", $realtime, exp_v.g, got.g); end
        if (got.b !== exp_v.b) begin errors++;
          $display("%0t: color_b exp %h got %h", $realtime, exp_v.b, got.b); end
        if (got.a !== exp_v.a) begin errors++;
          $display("%0t: color_a exp %h got %h", $realtime, exp_v.a, got.a); end
        if (got.last !== exp_v.last) begin errors++;
          $display("%0t: last_vertex exp %b got %b", $realtime, exp_v.last, got.last); end
      end
    end
  end

  // valid stays up after a transfer until an idle cycle or the next face
  task automatic send_face(input logic [IN_W-1:0] face);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    shade_face(face);
    s_axis_tdata  <= face;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    faces_sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (vertex_queue.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ROW0:    shade_regs.row0    = val[ROW_BITS-1:0];
      REG_ROW1:    shade_regs.row1    = val[ROW_BITS-1:0];
      REG_ROW2:    shade_regs.row2    = val[ROW_BITS-1:0];
      REG_LIGHT:   shade_regs.light   = val[ROW_BITS-1:0];
      REG_AMBIENT: shade_regs.ambient = val;
      REG_DIFFUSE: shade_regs.diffuse = val;
      default: ;
    endcase
  endtask

  function automatic logic [IN_W-1:0] random_face();
    logic [IN_W-1:0] f;
    for (int i = 0; i < NUM_ROT; i++) begin
      case ($urandom_range(5))
        0: f[i*CB +: CB] = {1'b0, {(CB-1){1'b1}}};
        1: f[i*CB +: CB] = {1'b1, {(CB-1){1'b0}}};
        2: f[i*CB +: CB] = CB'($signed($urandom_range(512)) - 256);
        default: f[i*CB +: CB] = CB'($urandom);
      endcase
    end
    return f;
  endfunction

  function automatic logic [63:0] random_row();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    logic [IN_W-1:0] f;
    // unit square facing away from the light, then facing it
    send_face({CB'(0), CB'(16384), CB'(0), CB'(0), CB'(16384), CB'(16384),
               CB'(0), CB'(0), CB'(16384), CB'(0), CB'(0), CB'(0)});
    send_face({CB'(0), CB'(0), CB'(16384), CB'(0), CB'(16384), CB'(16384),
               CB'(0), CB'(16384), CB'(0), CB'(0), CB'(0), CB'(0)});
    send_face('0);                                   // degenerate
    send_face({NUM_ROT{CB'(16'h1234)}});             // all corners equal
    send_face({NUM_ROT{{1'b0, {(CB-1){1'b1}}}}});
    send_face({NUM_ROT{{1'b1, {(CB-1){1'b0}}}}});
    send_face({(IN_W/2){2'b01}});
    send_face({(IN_W/2){2'b10}});
    send_face('1);
    f = '0; f[CB +: CB] = 16'h7FFF; f[4*CB +: CB] = 16'h8000; f[6*CB +: CB] = 16'h7FFF;
    send_face(f);
    // collinear corners
    send_face({CB'(0), CB'(0), CB'(300), CB'(0), CB'(0), CB'(200),
               CB'(0), CB'(0), CB'(100), CB'(0), CB'(0), CB'(0)});
    for (int i = 0; i < 8; i++) send_face(random_face());
    drain();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_face(random_face());
  endtask

  task automatic test_config_extremes();
    write_reg(REG_ROW0, '1);
    write_reg(REG_ROW1, {16'h8000, 16'h8000, 16'h8000});
    write_reg(REG_ROW2, {16'h7FFF, 16'h7FFF, 16'h7FFF});
    write_reg(REG_LIGHT, {16'h7FFF, 16'h8000, 16'h7FFF});
    write_reg(REG_AMBIENT, '1);
    write_reg(REG_DIFFUSE, '1);
    test_random(30);
    drain();
    write_reg(REG_ROW0, '0);
    write_reg(REG_ROW1, '0);
    write_reg(REG_ROW2, '0);
    write_reg(REG_LIGHT, '0);
    write_reg(REG_AMBIENT, '0);
    write_reg(REG_DIFFUSE, '0);
    test_random(15);
    drain();
    write_reg(3'd7, '1);                             // unknown index, dropped
    write_reg(REG_ROW0, 48'd16384);
    write_reg(REG_ROW1, 48'd16384 << 16);
    write_reg(REG_ROW2, 48'd16384 << 32);
    write_reg(REG_LIGHT, {16'h4000, 16'hC000, 16'h2000});
    write_reg(REG_AMBIENT, {16'h1000, 16'h2000, 16'h3000, 16'hFFF0});
    write_reg(REG_DIFFUSE, {16'hFFFF, 16'h8000, 16'h4000, 16'h0001});
    test_random(30);
    drain();
  endtask

  task automatic test_random_config();
    for (int set = 0; set < 4; set++) begin
      write_reg(REG_ROW0, random_row());
      write_reg(REG_ROW1, random_row());
      write_reg(REG_ROW2, random_row());
      write_reg(REG_LIGHT, random_row());
      write_reg(REG_AMBIENT, random_row() >> $urandom_range(63));
      write_reg(REG_DIFFUSE, random_row());
      test_random(25);
      drain();
    end
  endtask

  task automatic test_backpressure();
    // receiver holds off while more faces come than the pipeline holds
    hold_off = 400;
    test_random(80);
    drain();
    // sender waits for all vertices before the next face
    for (int i = 0; i < 10; i++) begin
      send_face(random_face());
      drain();
    end
  endtask

  initial begin
    shade_regs = '{RST_ROW0, RST_ROW1, RST_ROW2, RST_LIGHT, RST_AMBIENT, RST_DIFFUSE};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 8;  recv_idle_pct = 49;
    test_directed();
    test_random(60);
    drain();
    send_idle_pct = 49; recv_idle_pct = 8;
    test_config_extremes();
    send_idle_pct = 0;  recv_idle_pct = 0;
    test_random_config();
    test_random(60);
    drain();
    send_idle_pct = 8;  recv_idle_pct = 49;
    test_backpressure();
    $display("Covered %0d faces, %0d vertices, %0d degenerate, register extremes",
             faces_sent, verts_seen, degenerate_faces);
    $display("and random settings, long receiver hold-off and paced sending.");
    if (errors == 0 && vertex_queue.size() == 0)
      $display("tb_flat_shaded_quad_lighting: clean");
    else
      $display("tb_flat_shaded_quad_lighting: errors");
    $finish;
  end

endmodule

// ----- flat_shaded_quad_lighting.f -----
src/fsq_pkg.sv
src/fsq_rotate.sv
src/fsq_normal.sv
src/fsq_shade.sv
src/fsq_serial.sv
src/flat_shaded_quad_lighting.sv
src/fsq_checker.sv
tb/sv/tb_flat_shaded_quad_lighting.sv
